### sv/sdbr_pkg.sv
// sdbr_pkg: shared types, codes and the crc-16 byte fold for the sd data block receiver
// no dependencies; used by sdbr_out_buf and sd_data_block_receiver_top
package sdbr_pkg;

    // input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOKEN   = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // tokens on the card side
    localparam logic [7:0] TOKEN_START = 8'hfe;
    localparam logic [7:0] TOKEN_IDLE  = 8'hff;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_TOP   = 16'h8000;
    localparam logic [23:0] TIMER_MAX = 24'hffffff;
    localparam logic [23:0] TIMEOUT_RESET = 24'd200000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last;
    } result_t;

    // crc-16-ccitt, msb first, one byte folded in
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### sv/sd_data_block_receiver_top.sv
// sd data block receiver: token hunt, data byte pass-through, crc-16 check, hunt timeout
// a result word is registered in sdbr_out_buf; out_valid shows it from the output register
// throughput: one input word per cycle; in_ready drops only when both result slots are full
// cfg_ready is always high; timeout_reg is loaded from cfg_data in the cycle it is written
// reset (rst_n, async, active low): phase idle, counters and crc cleared, timeout 200000
// depends on sdbr_pkg and sdbr_out_buf
module sd_data_block_receiver_top #(
    parameter int MAX_BLOCK = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    // input word channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  byte_value,
    input  logic [9:0]  block_length,
    // result word channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_status,
    output logic [7:0]  data_byte,
    output logic [1:0]  status,
    output logic        last
);

    // width that holds any legal MAX_BLOCK for the length clamp compare
    localparam int LenCmpW = 13;

    // transfer state
    sdbr_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      crc_reg, crc_next;
    logic [9:0]       seen_reg, seen_next;
    logic [9:0]       expected_reg, expected_next;
    logic [23:0]      timer_reg, timer_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic [23:0]      timeout_reg;

    // per-word scratch
    logic              accept;
    logic              res_valid;
    sdbr_pkg::result_t res_word;
    sdbr_pkg::result_t out_word;
    logic [9:0]        len_clamped;
    logic [9:0]        seen_inc;
    logic [23:0]       timer_inc;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // zero length means one byte; anything above MAX_BLOCK is cut to MAX_BLOCK
    always_comb
    begin
        if (block_length == 10'd0)
            len_clamped = 10'd1;
        else if ({{(LenCmpW - 10){1'b0}}, block_length} > LenCmpW'(MAX_BLOCK))
            len_clamped = 10'(MAX_BLOCK);
        else
            len_clamped = block_length;
    end

    assign seen_inc  = seen_reg + 10'd1;
    // hunt timer sticks at all ones
    assign timer_inc = (timer_reg == sdbr_pkg::TIMER_MAX) ? timer_reg : timer_reg + 24'd1;

    // next state and result word for the accepted input word
    always_comb
    begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        seen_next     = seen_reg;
        expected_next = expected_reg;
        timer_next    = timer_reg;
        crc_hi_next   = crc_hi_reg;
        res_valid     = 1'b0;
        res_word      = '0;
        if (accept)
        begin
            unique case (opcode)
                sdbr_pkg::OP_START:
                begin
                    // a start while busy drops the running transfer
                    expected_next = len_clamped;
                    seen_next     = 10'd0;
                    crc_next      = 16'h0000;
                    timer_next    = 24'd0;
                    crc_hi_next   = 8'h00;
                    phase_next    = sdbr_pkg::PH_HUNT;
                end
                sdbr_pkg::OP_TICK:
                begin
                    if (phase_reg == sdbr_pkg::PH_HUNT)
                    begin
                        timer_next = timer_inc;
                        if (timer_inc >= timeout_reg)
                        begin
                            phase_next         = sdbr_pkg::PH_IDLE;
                            res_valid          = 1'b1;
                            res_word.is_status = 1'b1;
                            res_word.status    = sdbr_pkg::ST_TIMEOUT;
                            res_word.last      = 1'b1;
                        end
                    end
                end
                sdbr_pkg::OP_BYTE:
                begin
                    unique case (phase_reg)
                        sdbr_pkg::PH_HUNT:
                        begin
                            // fill bytes are skipped, start token opens the data phase
                            if (byte_value == sdbr_pkg::TOKEN_START)
                                phase_next = sdbr_pkg::PH_DATA;
                            else if (byte_value != sdbr_pkg::TOKEN_IDLE)
                            begin
                                phase_next         = sdbr_pkg::PH_IDLE;
                                res_valid          = 1'b1;
                                res_word.is_status = 1'b1;
                                res_word.data_byte = byte_value;
                                res_word.status    = sdbr_pkg::ST_TOKEN;
                                res_word.last      = 1'b1;
                            end
                        end
                        sdbr_pkg::PH_DATA:
                        begin
                            crc_next           = sdbr_pkg::crc_fold(crc_reg, byte_value);
                            seen_next          = seen_inc;
                            res_valid          = 1'b1;
                            res_word.data_byte = byte_value;
                            if (seen_inc >= expected_reg)
                                phase_next = sdbr_pkg::PH_CRC_HI;
                        end
                        sdbr_pkg::PH_CRC_HI:
                        begin
                            crc_hi_next = byte_value;
                            phase_next  = sdbr_pkg::PH_CRC_LO;
                        end
                        sdbr_pkg::PH_CRC_LO:
                        begin
                            // trailing crc is big-endian
                            phase_next         = sdbr_pkg::PH_IDLE;
                            res_valid          = 1'b1;
                            res_word.is_status = 1'b1;
                            res_word.last      = 1'b1;
                            res_word.status    = ({crc_hi_reg, byte_value} == crc_reg)
                                                 ? sdbr_pkg::ST_OK : sdbr_pkg::ST_CRC;
                        end
                        default:
                        begin
                            // bytes while idle are dropped
                        end
                    endcase
                end
                default:
                begin
                    // unused opcode, no effect
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= sdbr_pkg::PH_IDLE;
            crc_reg      <= 16'h0000;
            seen_reg     <= 10'd0;
            expected_reg <= 10'd0;
            timer_reg    <= 24'd0;
            crc_hi_reg   <= 8'h00;
            timeout_reg  <= sdbr_pkg::TIMEOUT_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            seen_reg     <= seen_next;
            expected_reg <= expected_next;
            timer_reg    <= timer_next;
            crc_hi_reg   <= crc_hi_next;
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
        end
    end

    // result register with skid slot; in_ready comes straight off its skid flag
    sdbr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_word (res_word),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign is_status = out_word.is_status;
    assign data_byte = out_word.data_byte;
    assign status    = out_word.status;
    assign last      = out_word.last;

    // data words carry ok status and never close the transfer
    a_data_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_status) |-> (status == sdbr_pkg::ST_OK && !last))
        else $error("malformed data word");

    // every status word closes the transfer
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_status) |-> last)
        else $error("status word without last");

    // a produced status result always returns the receiver to idle
    a_status_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.is_status) |=> (phase_reg == sdbr_pkg::PH_IDLE))
        else $error("status issued but transfer still active");

    // byte counter never runs past the armed length
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sdbr_pkg::PH_DATA) |-> (seen_reg < expected_reg))
        else $error("byte count overran block length");

endmodule

### sv/sdbr_out_buf.sv
// sdbr_out_buf: two-entry result buffer (output register plus skid slot)
// depends on sdbr_pkg for the result word type
module sdbr_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sdbr_pkg::result_t push_word,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output sdbr_pkg::result_t out_word
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    sdbr_pkg::result_t main_reg, main_next;
    sdbr_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_word;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // skid slot only fills behind a held output word
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word without output word");

    // a stalled output plus a new word must park it in the skid slot
    a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (push && can_push && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("word lost on stalled output");

endmodule
